// File: rtl/dcmq_pkg.sv
package dcmq_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 30;

	// which square-root form the item takes
	typedef enum logic [1:0] {
		FORM_TRACE,
		FORM_D0,
		FORM_D1,
		FORM_D2
	} form_t;

	// control that rides along with the datapath
	typedef struct packed {
		form_t      form;
		logic       bad;
		logic       half_neg;
		logic [2:0] num_neg;
	} ctl_t;

	// bits of the integer square root of (radicand << frac)
	function automatic int root_bits(input int w, input int f);
		int nb;
		nb = w + 3 + f;
		if ((nb % 2) != 0) begin
			nb = nb + 1;
		end
		return nb / 2;
	endfunction

endpackage

// File: rtl/dcmq_select.sv
module dcmq_select #(
	parameter int DATA_WIDTH = dcmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic signed [DATA_WIDTH-1:0]   in_elem [9],
	output logic                           out_valid,
	output logic [DATA_WIDTH+1:0]          out_rad,
	output dcmq_pkg::ctl_t                 out_ctl,
	output logic [DATA_WIDTH:0]            out_mag [3]
);
	import dcmq_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic signed [W+2:0] ONE = (W+3)'(1) << FRAC_BITS;

	function automatic logic signed [W+2:0] sx3(input logic signed [W-1:0] v);
		return {{3{v[W-1]}}, v};
	endfunction

	function automatic logic signed [W:0] sx1(input logic signed [W-1:0] v);
		return {v[W-1], v};
	endfunction

	logic [2:0]              vld_s;
	logic signed [W-1:0]     elem_s1 [9];
	logic signed [W+1:0]     trace_s1;
	form_t                   form_s1;
	logic signed [W+2:0]     rad_s2;
	logic signed [W:0]       num_s2 [3];
	form_t                   form_s2;
	logic [W+1:0]            rad_s3;
	logic [W:0]              mag_s3 [3];
	ctl_t                    ctl_s3;

	logic signed [W+1:0]     trace_c;
	form_t                   form_c;
	logic                    t0_c, t1_c, t2_c;
	logic signed [W+2:0]     rad_c;
	logic signed [W:0]       num_c [3];
	logic                    flip_c;
	logic                    bad_c;
	logic [W:0]              mag_c [3];
	logic [2:0]              neg_c;

	// stage 1: trace and the largest of trace and diagonal, earliest on a tie
	always_comb begin
		trace_c = {{2{in_elem[0][W-1]}}, in_elem[0]} + {{2{in_elem[4][W-1]}}, in_elem[4]}
			+ {{2{in_elem[8][W-1]}}, in_elem[8]};
		t0_c = ($signed({{2{in_elem[0][W-1]}}, in_elem[0]}) > trace_c) &&
			(in_elem[0] >= in_elem[4]) && (in_elem[0] >= in_elem[8]);
		t1_c = ($signed({{2{in_elem[4][W-1]}}, in_elem[4]}) > trace_c) &&
			(in_elem[4] > in_elem[0]) && (in_elem[4] >= in_elem[8]);
		t2_c = ($signed({{2{in_elem[8][W-1]}}, in_elem[8]}) > trace_c) &&
			(in_elem[8] > in_elem[0]) && (in_elem[8] > in_elem[4]);
		priority if (t2_c) begin
			form_c = FORM_D2;
		end else if (t1_c) begin
			form_c = FORM_D1;
		end else if (t0_c) begin
			form_c = FORM_D0;
		end else begin
			form_c = FORM_TRACE;
		end
	end

	// stage 2: radicand and the three numerators of the chosen form
	always_comb begin
		unique case (form_s1)
			FORM_TRACE: begin
				rad_c    = ONE + {trace_s1[W+1], trace_s1};
				num_c[0] = sx1(elem_s1[7]) - sx1(elem_s1[5]);
				num_c[1] = sx1(elem_s1[2]) - sx1(elem_s1[6]);
				num_c[2] = sx1(elem_s1[3]) - sx1(elem_s1[1]);
			end
			FORM_D0: begin
				rad_c    = ONE + sx3(elem_s1[0]) - sx3(elem_s1[4]) - sx3(elem_s1[8]);
				num_c[0] = sx1(elem_s1[1]) + sx1(elem_s1[3]);
				num_c[1] = sx1(elem_s1[2]) + sx1(elem_s1[6]);
				num_c[2] = sx1(elem_s1[7]) - sx1(elem_s1[5]);
			end
			FORM_D1: begin
				rad_c    = ONE + sx3(elem_s1[4]) - sx3(elem_s1[8]) - sx3(elem_s1[0]);
				num_c[0] = sx1(elem_s1[5]) + sx1(elem_s1[7]);
				num_c[1] = sx1(elem_s1[3]) + sx1(elem_s1[1]);
				num_c[2] = sx1(elem_s1[2]) - sx1(elem_s1[6]);
			end
			FORM_D2: begin
				rad_c    = ONE + sx3(elem_s1[8]) - sx3(elem_s1[0]) - sx3(elem_s1[4]);
				num_c[0] = sx1(elem_s1[6]) + sx1(elem_s1[2]);
				num_c[1] = sx1(elem_s1[7]) + sx1(elem_s1[5]);
				num_c[2] = sx1(elem_s1[3]) - sx1(elem_s1[1]);
			end
			default: begin
				rad_c    = ONE;
				num_c[0] = '0;
				num_c[1] = '0;
				num_c[2] = '0;
			end
		endcase
	end

	// stage 3: sign flip for the diagonal forms, sign and magnitude split, non-positive radicand check
	always_comb begin
		flip_c = (form_s2 != FORM_TRACE) && num_s2[2][W];
		bad_c  = rad_s2[W+2] || (rad_s2 == '0);
		for (int j = 0; j < 3; j++) begin
			neg_c[j] = num_s2[j][W] ^ flip_c;
			mag_c[j] = num_s2[j][W] ? (W+1)'(-num_s2[j]) : num_s2[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elem_s1          <= in_elem;
			trace_s1         <= trace_c;
			form_s1          <= form_c;
			rad_s2           <= rad_c;
			num_s2           <= num_c;
			form_s2          <= form_s1;
			rad_s3           <= bad_c ? (W+2)'(1) : rad_s2[W+1:0];
			mag_s3           <= mag_c;
			ctl_s3.form      <= form_s2;
			ctl_s3.bad       <= bad_c;
			ctl_s3.half_neg  <= flip_c;
			ctl_s3.num_neg   <= neg_c;
		end
	end

	assign out_valid = vld_s[2];
	assign out_rad   = rad_s3;
	assign out_ctl   = ctl_s3;
	assign out_mag   = mag_s3;

endmodule

// File: rtl/dcmq_sqrt.sv
module dcmq_sqrt #(
	parameter int DATA_WIDTH = dcmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           in_valid,
	input  logic [DATA_WIDTH+1:0]                          in_rad,
	input  dcmq_pkg::ctl_t                                 in_ctl,
	input  logic [DATA_WIDTH:0]                            in_mag [3],
	output logic                                           out_valid,
	output logic [dcmq_pkg::root_bits(DATA_WIDTH, FRAC_BITS):0] out_root,
	output dcmq_pkg::ctl_t                                 out_ctl,
	output logic [DATA_WIDTH:0]                            out_mag [3]
);
	import dcmq_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int RW = root_bits(DATA_WIDTH, FRAC_BITS);
	localparam int NB = 2 * RW;
	localparam int SW = RW + 1;

	// one root bit per stage, then a rounding stage
	logic [RW:0]     vld_s;
	logic [W+1:0]    rad_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [RW+1:0]   rem_s  [RW];
	ctl_t            ctl_s  [RW];
	logic [W:0]      mag_s  [RW][3];
	logic [SW-1:0]   rroot_s;
	ctl_t            rctl_s;
	logic [W:0]      rmag_s [3];

	logic [W+1:0]    rad_p  [RW];
	logic [RW-1:0]   root_p [RW];
	logic [RW+1:0]   rem_p  [RW];
	ctl_t            ctl_p  [RW];
	logic [W:0]      mag_p  [RW][3];
	logic [RW-1:0]   root_n [RW];
	logic [RW+1:0]   rem_n  [RW];
	logic [SW-1:0]   rnd_c;

	always_comb begin
		rad_p[0]  = in_rad;
		root_p[0] = '0;
		rem_p[0]  = '0;
		ctl_p[0]  = in_ctl;
		mag_p[0]  = in_mag;
		for (int k = 1; k < RW; k++) begin
			rad_p[k]  = rad_s[k-1];
			root_p[k] = root_s[k-1];
			rem_p[k]  = rem_s[k-1];
			ctl_p[k]  = ctl_s[k-1];
			mag_p[k]  = mag_s[k-1];
		end
	end

	// restoring square root, two radicand bits per stage
	always_comb begin
		logic [NB-1:0]   x;
		logic [RW+3:0]   rx;
		logic [RW+3:0]   trial;
		logic            ge;
		for (int k = 0; k < RW; k++) begin
			x         = NB'(rad_p[k]) << FRAC_BITS;
			rx        = {rem_p[k], x[NB-2-2*k +: 2]};
			trial     = {2'b00, root_p[k], 2'b01};
			ge        = rx >= trial;
			rx        = ge ? rx - trial : rx;
			rem_n[k]  = rx[RW+1:0];
			root_n[k] = {root_p[k][RW-2:0], ge};
		end
	end

	// round to nearest: up when the remainder passes the root
	assign rnd_c = {1'b0, root_s[RW-1]} +
		SW'(rem_s[RW-1] > {2'b00, root_s[RW-1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rad_s[k]  <= rad_p[k];
				root_s[k] <= root_n[k];
				rem_s[k]  <= rem_n[k];
				ctl_s[k]  <= ctl_p[k];
				mag_s[k]  <= mag_p[k];
			end
			rroot_s <= rnd_c;
			rctl_s  <= ctl_s[RW-1];
			rmag_s  <= mag_s[RW-1];
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = rroot_s;
	assign out_ctl   = rctl_s;
	assign out_mag   = rmag_s;

endmodule

// File: rtl/dcmq_div.sv
module dcmq_div #(
	parameter int DATA_WIDTH = dcmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           in_valid,
	input  logic [dcmq_pkg::root_bits(DATA_WIDTH, FRAC_BITS):0] in_root,
	input  dcmq_pkg::ctl_t                                 in_ctl,
	input  logic [DATA_WIDTH:0]                            in_mag [3],
	output logic                                           out_valid,
	output logic [DATA_WIDTH-1:0]                          out_qr [3],
	output logic [2:0]                                     out_ovf,
	output logic [DATA_WIDTH-2:0]                          out_half,
	output dcmq_pkg::ctl_t                                 out_ctl
);
	import dcmq_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int SW = root_bits(DATA_WIDTH, FRAC_BITS) + 1;
	localparam int NS = DATA_WIDTH + FRAC_BITS;
	localparam int HW = (SW > W) ? SW : W;

	// three quotient lanes share the divisor, one quotient bit per stage
	logic [NS:0]     vld_s;
	logic [SW-1:0]   s_s   [NS];
	ctl_t            ctl_s [NS];
	logic [W:0]      mag_s [NS][3];
	logic [SW-1:0]   rem_s [NS][3];
	logic [W-2:0]    q_s   [NS][3];
	logic [2:0]      ovf_s [NS];
	logic [W-1:0]    qr_s  [3];
	logic [2:0]      rovf_s;
	logic [W-2:0]    half_s;
	ctl_t            rctl_s;

	logic [SW-1:0]   s_p   [NS];
	ctl_t            ctl_p [NS];
	logic [W:0]      mag_p [NS][3];
	logic [SW-1:0]   rem_p [NS][3];
	logic [W-2:0]    q_p   [NS][3];
	logic [2:0]      ovf_p [NS];
	logic [SW-1:0]   rem_n [NS][3];
	logic [W-2:0]    q_n   [NS][3];
	logic [2:0]      ovf_n [NS];
	logic [W-1:0]    qr_c  [3];
	logic [W-2:0]    half_c;

	always_comb begin
		s_p[0]   = in_root;
		ctl_p[0] = in_ctl;
		mag_p[0] = in_mag;
		ovf_p[0] = '0;
		for (int j = 0; j < 3; j++) begin
			rem_p[0][j] = '0;
			q_p[0][j]   = '0;
		end
		for (int k = 1; k < NS; k++) begin
			s_p[k]   = s_s[k-1];
			ctl_p[k] = ctl_s[k-1];
			mag_p[k] = mag_s[k-1];
			rem_p[k] = rem_s[k-1];
			q_p[k]   = q_s[k-1];
			ovf_p[k] = ovf_s[k-1];
		end
	end

	// restoring division of (mag << (frac-1)) by the root
	always_comb begin
		logic [NS-1:0]   dvd;
		logic [SW:0]     rx;
		logic            ge;
		for (int k = 0; k < NS; k++) begin
			for (int j = 0; j < 3; j++) begin
				dvd          = NS'(mag_p[k][j]) << (FRAC_BITS - 1);
				rx           = {rem_p[k][j], dvd[NS-1-k]};
				ge           = rx >= {1'b0, s_p[k]};
				rx           = ge ? rx - {1'b0, s_p[k]} : rx;
				rem_n[k][j]  = rx[SW-1:0];
				q_n[k][j]    = {q_p[k][j][W-3:0], ge};
				// any quotient bit at or above the sign position saturates
				ovf_n[k][j]  = ovf_p[k][j] | (ge && ((NS - 1 - k) >= (W - 1)));
			end
		end
	end

	// round half away from zero, and half the root for the main component
	always_comb begin
		logic [SW:0]   hsum;
		logic [HW-1:0] hext;
		for (int j = 0; j < 3; j++) begin
			qr_c[j] = {1'b0, q_s[NS-1][j]} +
				W'(!ovf_s[NS-1][j] && ({rem_s[NS-1][j], 1'b0} >= {1'b0, s_s[NS-1]}));
		end
		hsum   = {1'b0, s_s[NS-1]} + (SW+1)'(1);
		hext   = HW'(hsum[SW:1]);
		half_c = (hext > HW'({1'b0, {(W-1){1'b1}}})) ? {(W-1){1'b1}} : hext[W-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				s_s[k]   <= s_p[k];
				ctl_s[k] <= ctl_p[k];
				mag_s[k] <= mag_p[k];
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
				ovf_s[k] <= ovf_n[k];
			end
			qr_s   <= qr_c;
			rovf_s <= ovf_s[NS-1];
			half_s <= half_c;
			rctl_s <= ctl_s[NS-1];
		end
	end

	assign out_valid = vld_s[NS];
	assign out_qr    = qr_s;
	assign out_ovf   = rovf_s;
	assign out_half  = half_s;
	assign out_ctl   = rctl_s;

endmodule

// File: rtl/dcm_to_quaternion_core.sv
// Rotation matrix to unit quaternion by Shepperd's method, fully pipelined. Each item is a 3x3
// matrix of signed Qm.FRAC_BITS elements (row major, r0c0 in the lowest bits of s_tdata); each
// result is the quaternion (scalar, x, y, z) in the same format, with the scalar kept non-negative,
// plus the chosen form and a bad-matrix flag in m_tuser. The form is the largest of the trace and
// the three diagonal elements (trace first, then the lower index on a tie). A radicand that is not
// positive gives an all-zero quaternion with bad_matrix set. Components saturate to the signed
// DATA_WIDTH range. One item is accepted every cycle while s_tready is high. The pipeline holds three
// select stages, one stage per bit of the restoring square root and its rounding, one stage per
// quotient bit of the three shared-divisor dividers and their rounding, and the output register. A
// two-entry output buffer lets the pipeline keep moving while one result waits; s_tready drops only
// when both entries are full.
module dcm_to_quaternion_core #(
	parameter int DATA_WIDTH = dcmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1, elem_r1c2,
	// elem_r2c0, elem_r2c1, elem_r2c2, zero fill
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]             s_tdata,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// quat_w, quat_x, quat_y, quat_z, zero fill
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0]             m_tdata,
	// form_used[1:0], bad_matrix
	output logic [2:0]                                    m_tuser
);
	import dcmq_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int SW     = root_bits(DATA_WIDTH, FRAC_BITS) + 1;
	localparam int OUT_TW = ((4*DATA_WIDTH+7)/8)*8;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// pipeline advance: held only while the output buffer is full
	logic                en;
	logic signed [W-1:0] elem [9];

	logic                sel_valid;
	logic [W+1:0]        sel_rad;
	ctl_t                sel_ctl;
	logic [W:0]          sel_mag [3];

	logic                sq_valid;
	logic [SW-1:0]       sq_root;
	ctl_t                sq_ctl;
	logic [W:0]          sq_mag [3];

	logic                dv_valid;
	logic [W-1:0]        dv_qr [3];
	logic [2:0]          dv_ovf;
	logic [W-2:0]        dv_half;
	ctl_t                dv_ctl;

	logic [W-1:0]        lane_c [3];
	logic [W-1:0]        hv_c;
	logic [W-1:0]        quat_c [4];
	logic [OUT_TW-1:0]   data_c;
	logic [2:0]          user_c;
	logic                push;

	logic                main_vld_q;
	logic [OUT_TW-1:0]   main_data_q;
	logic [2:0]          main_user_q;
	logic                skid_vld_q;
	logic [OUT_TW-1:0]   skid_data_q;
	logic [2:0]          skid_user_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign push     = en && dv_valid;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			elem[i] = s_tdata[i*W +: W];
		end
	end

	// trace or diagonal choice, radicand and numerators
	dcmq_select #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_elem   (elem),
		.out_valid (sel_valid),
		.out_rad   (sel_rad),
		.out_ctl   (sel_ctl),
		.out_mag   (sel_mag)
	);

	// rounded root of the radicand in Q.FRAC_BITS
	dcmq_sqrt #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sel_valid),
		.in_rad    (sel_rad),
		.in_ctl    (sel_ctl),
		.in_mag    (sel_mag),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_ctl   (sq_ctl),
		.out_mag   (sq_mag)
	);

	// numerator / (2 * root) for the three other components
	dcmq_div #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_root   (sq_root),
		.in_ctl    (sq_ctl),
		.in_mag    (sq_mag),
		.out_valid (dv_valid),
		.out_qr    (dv_qr),
		.out_ovf   (dv_ovf),
		.out_half  (dv_half),
		.out_ctl   (dv_ctl)
	);

	// sign, saturation and placement of the components by form
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (dv_ctl.num_neg[j]) begin
				lane_c[j] = dv_ovf[j] ? MINV : W'(-dv_qr[j]);
			end else begin
				lane_c[j] = (dv_ovf[j] || dv_qr[j][W-1]) ? MAXV : dv_qr[j];
			end
		end
		hv_c = dv_ctl.half_neg ? W'(-{1'b0, dv_half}) : {1'b0, dv_half};
		unique case (dv_ctl.form)
			FORM_TRACE: begin
				quat_c[0] = hv_c;
				quat_c[1] = lane_c[0];
				quat_c[2] = lane_c[1];
				quat_c[3] = lane_c[2];
			end
			FORM_D0: begin
				quat_c[0] = lane_c[2];
				quat_c[1] = hv_c;
				quat_c[2] = lane_c[0];
				quat_c[3] = lane_c[1];
			end
			FORM_D1: begin
				quat_c[0] = lane_c[2];
				quat_c[1] = lane_c[1];
				quat_c[2] = hv_c;
				quat_c[3] = lane_c[0];
			end
			FORM_D2: begin
				quat_c[0] = lane_c[2];
				quat_c[1] = lane_c[0];
				quat_c[2] = lane_c[1];
				quat_c[3] = hv_c;
			end
			default: begin
				quat_c[0] = '0;
				quat_c[1] = '0;
				quat_c[2] = '0;
				quat_c[3] = '0;
			end
		endcase
		// malformed matrix: zero quaternion, form still reported
		if (dv_ctl.bad) begin
			for (int i = 0; i < 4; i++) begin
				quat_c[i] = '0;
			end
		end
		data_c = OUT_TW'({quat_c[3], quat_c[2], quat_c[1], quat_c[0]});
		user_c = {dv_ctl.bad, dv_ctl.form};
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || m_tready) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || m_tready) begin
			if (skid_vld_q) begin
				main_data_q <= skid_data_q;
				main_user_q <= skid_user_q;
			end else begin
				main_data_q <= data_c;
				main_user_q <= user_c;
			end
		end else if (push) begin
			skid_data_q <= data_c;
			skid_user_q <= user_c;
		end
	end

	assign m_tvalid = main_vld_q;
	assign m_tdata  = main_data_q;
	assign m_tuser  = main_user_q;

`ifndef SYNTHESIS
	// a held input side means a result is on offer
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result on offer");

	// bad matrix gives an all-zero quaternion
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tdata[4*W-1:0] == '0))
		else $error("bad matrix result not zeroed");

	// scalar part is never negative
	a_scalar_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[2]) |-> !m_tdata[W-1])
		else $error("negative quaternion scalar");
`endif

endmodule
